FILE: sv/assert_macros.svh
// Assertion macros shared by the tone generator RTL.
// No dependencies; included by the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/eatg_pkg.sv
// Package for the enveloped alarm tone generator: constants, types, sine function.
// No dependencies; used by every module of the block but the divider.
`timescale 1ns / 1ps
package eatg_pkg;

  localparam int unsigned SineDepthDef = 1024;
  localparam int unsigned PhaseWidthDef = 24;
  localparam int unsigned LengthWidthDef = 16;

  localparam int unsigned StepW = 23;
  localparam int unsigned InLenW = 16;
  localparam int unsigned RepW = 8;
  localparam int unsigned GainW = 16;
  localparam int unsigned SampleW = 16;
  localparam int unsigned ScaleW = 15;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgGapLength = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgOutputScale = 2'd1;
  localparam logic [15:0] GapLengthRst = 16'd2400;
  localparam logic [ScaleW-1:0] OutputScaleRst = 15'd14000;

  localparam logic [GainW-1:0] GainOne = 16'd32768;
  localparam int unsigned EnvFrac = 16;
  localparam int unsigned EnvW = 17;
  localparam logic [13:0] HarmQ15 = 14'd7209;
  localparam int unsigned MulW = 18;
  localparam int unsigned ProdW = 36;

  localparam longint unsigned C1 = 64'd1686629713;
  localparam longint unsigned C2 = 64'd693598669;
  localparam longint unsigned C3 = 64'd85569306;
  localparam longint unsigned C4 = 64'd5026994;

  typedef enum logic [3:0] {
    ST_IDLE, ST_REL, ST_ENVSEL, ST_ENV, ST_ROM1, ST_ROM2,
    ST_HARM, ST_ENVMUL, ST_GAIN, ST_SCALE, ST_DONE
  } ctrl_state_e;

  typedef enum logic [2:0] {
    MUL_NONE, MUL_HARM, MUL_ENV, MUL_GAIN, MUL_SCALE
  } mul_op_e;

  typedef struct packed {
    logic     load;
    logic     tick_zero;
    logic     div_start;
    logic     rel_latch;
    logic     env_one;
    logic     env_latch;
    logic     rom_rd;
    logic     rom_hi;
    logic     s1_latch;
    mul_op_e  mul_op;
    logic     finish;
  } dp_cmd_t;

  typedef struct packed {
    logic gap_nz;
    logic tone_z;
    logic div_done;
    logic env_full;
  } dp_sts_t;

  // Q1.15 sine entry k of a table of 2**lg entries (quarter-wave odd polynomial).
  function automatic logic signed [15:0] sine_entry(input int unsigned k,
                                                   input int unsigned lg);
    logic [63:0] u, quad, rem, t, t2, a, b, c, s, r;
    logic [15:0] rr;
    u = 64'(k) << 2;
    quad = (u >> lg) & 64'd3;
    rem = u & ((64'd1 << lg) - 64'd1);
    t = (rem << 30) >> lg;
    if (quad[0]) t = (64'd1 << 30) - t;
    t2 = (t * t) >> 30;
    a = C3 - ((t2 * C4) >> 30);
    b = C2 - ((t2 * a) >> 30);
    c = C1 - ((t2 * b) >> 30);
    s = (t * c) >> 30;
    r = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    if (r > 64'd32767) r = 64'd32767;
    rr = r[15:0];
    return quad[1] ? -rr : rr;
  endfunction

endpackage

FILE: sv/eatg_if.sv
// Valid/ready channel interface carrying one input item of the tone generator.
// Depends on eatg_pkg for field widths.
`timescale 1ns / 1ps
interface eatg_in_if;
  logic                            valid;
  logic                            ready;
  logic                            action;
  logic [eatg_pkg::StepW-1:0]      phase_step;
  logic [eatg_pkg::InLenW-1:0]     on_length;
  logic [eatg_pkg::RepW-1:0]       rep_count;
  logic [eatg_pkg::GainW-1:0]      gain;

  modport source (output valid, action, phase_step, on_length, rep_count, gain,
                  input ready);
  modport sink (input valid, action, phase_step, on_length, rep_count, gain,
                output ready);
endinterface

FILE: sv/eatg_out_if.sv
// Valid/ready channel interface carrying one audio sample beat.
// Depends on eatg_pkg for the sample width.
`timescale 1ns / 1ps
interface eatg_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [eatg_pkg::SampleW-1:0] sample;

  modport source (output valid, sample, input ready);
  modport sink (input valid, sample, output ready);
endinterface

FILE: sv/eatg_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
module eatg_div #(
  parameter int unsigned NumW = 32,
  parameter int unsigned DenW = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quot_o
);
  `include "assert_macros.svh"

  localparam int unsigned CntW = $clog2(NumW + 1);
  localparam logic [CntW-1:0] LastCnt = CntW'(NumW - 1);

  logic            busy_q, busy_d, done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DenW:0]   rem_q, rem_d, rem_sh;
  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW-1:0] den_q, den_d;
  logic            fits;

  always_comb begin
    rem_sh = {rem_q[DenW-1:0], quo_q[NumW-1]};
    fits = rem_sh >= {1'b0, den_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d = cnt_q;
    rem_d = rem_q;
    quo_d = quo_q;
    den_d = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d = '0;
      rem_d = '0;
      quo_d = num_i;
      den_d = den_i;
    end else if (busy_q) begin
      rem_d = fits ? rem_sh - {1'b0, den_q} : rem_sh;
      quo_d = {quo_q[NumW-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastCnt) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

  `ASSERT_NEXT(a_done_after_busy, clk_i, rst_ni, busy_q && cnt_q == LastCnt && !start_i, done_q, "divider did not finish")
  `ASSERT_ALWAYS(a_done_idle, clk_i, rst_ni, !(done_q && busy_q && !$past(start_i)), "divider busy at done")
endmodule

FILE: sv/eatg_dp.sv
// Datapath: burst counters, phase accumulator, sine ROM, envelope divider, shared multiplier.
// Depends on eatg_pkg, eatg_div and assert_macros.svh.
`timescale 1ns / 1ps
module eatg_dp #(
  parameter int unsigned SINE_TABLE_DEPTH = eatg_pkg::SineDepthDef,
  parameter int unsigned PHASE_WIDTH = eatg_pkg::PhaseWidthDef,
  parameter int unsigned LENGTH_WIDTH = eatg_pkg::LengthWidthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  eatg_pkg::dp_cmd_t              cmd_i,
  output eatg_pkg::dp_sts_t              sts_o,
  input  logic [eatg_pkg::StepW-1:0]     phase_step_i,
  input  logic [eatg_pkg::InLenW-1:0]    on_length_i,
  input  logic [eatg_pkg::RepW-1:0]      rep_count_i,
  input  logic [eatg_pkg::GainW-1:0]     gain_i,
  input  logic                           cfg_we_i,
  input  logic [eatg_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [eatg_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output logic signed [eatg_pkg::SampleW-1:0] sample_o
);
  import eatg_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned PW = PHASE_WIDTH;
  localparam int unsigned LW = LENGTH_WIDTH;
  localparam int unsigned Lg = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned NumW = LW + EnvFrac;
  // total / 5 as a reciprocal multiply, exact over the whole length range
  localparam int unsigned RelShift = LW + 3;
  localparam logic [LW:0] Recip5 = (LW+1)'(((64'd1 << RelShift) + 64'd4) / 64'd5);

  logic [15:0]        gap_len_q;
  logic [ScaleW-1:0]  scale_q;
  logic [PW-1:0]      phase_q, step_q;
  logic [GainW-1:0]   gain_q;
  logic [LW-1:0]      on_len_q, total_q, tone_q, gap_q, rel_q;
  logic [RepW-1:0]    rep_q;
  logic [EnvW-1:0]    env_q;
  logic signed [15:0] rom_q, s1_q;
  logic signed [ProdW-1:0] mul_q;
  logic signed [SampleW-1:0] sample_q;

  logic signed [15:0] sine_rom [SINE_TABLE_DEPTH];
  for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
    assign sine_rom[k] = sine_entry(k, Lg);
  end

  function automatic logic signed [ProdW-1:0] rnd(input logic signed [ProdW-1:0] x,
                                                  input int unsigned n);
    logic [ProdW-1:0] mag, r;
    mag = x[ProdW-1] ? -x : x;
    r = (mag + (ProdW'(1) << (n - 1))) >> n;
    return x[ProdW-1] ? -r : r;
  endfunction

  logic [LW-1:0]     played, attack, release_len;
  logic              use_attack;
  logic [2*LW+3:0]   rel_prod;
  logic [NumW-1:0]   div_num;
  logic [LW-1:0]     div_den;
  logic              div_done;
  logic [NumW-1:0]   div_quot;
  logic [PW-1:0]     phase2;
  logic [Lg-1:0]     rom_idx;
  logic signed [MulW-1:0] mul_a, mul_b;
  logic signed [ProdW-1:0] r15, r16, vt;
  logic signed [MulW-1:0] wave;
  logic signed [SampleW-1:0] sat;

  always_comb begin
    played = (tone_q > total_q) ? '0 : total_q - tone_q;
    attack = (total_q >> 3) == '0 ? LW'(1) : total_q >> 3;
    release_len = (rel_q == '0) ? LW'(1) : rel_q;
    use_attack = played < attack;
    rel_prod = (2*LW+4)'(total_q) * (2*LW+4)'(Recip5);
    sts_o.gap_nz = gap_q != '0;
    sts_o.tone_z = tone_q == '0;
    sts_o.div_done = div_done;
    sts_o.env_full = !use_attack && !(tone_q < release_len);
    if (use_attack) begin
      div_num = {played, EnvFrac'(0)};
      div_den = attack;
    end else begin
      div_num = {tone_q, EnvFrac'(0)};
      div_den = release_len;
    end
    phase2 = {phase_q[PW-2:0], 1'b0};
    rom_idx = cmd_i.rom_hi ? phase2[PW-1 -: Lg] : phase_q[PW-1 -: Lg];
    r15 = rnd(mul_q, 15);
    r16 = rnd(mul_q, 16);
    wave = MulW'(s1_q) + r15[MulW-1:0];
    unique case (cmd_i.mul_op)
      MUL_HARM: begin
        mul_a = MulW'(rom_q);
        mul_b = MulW'(HarmQ15);
      end
      MUL_ENV: begin
        mul_a = wave;
        mul_b = MulW'(env_q);
      end
      MUL_GAIN: begin
        mul_a = r16[MulW-1:0];
        mul_b = MulW'(gain_q);
      end
      MUL_SCALE: begin
        mul_a = r15[MulW-1:0];
        mul_b = MulW'(scale_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    vt = mul_q[ProdW-1] ? -((-mul_q) >>> 15) : mul_q >>> 15;
    if (vt > 36'sd32767) sat = 16'sh7fff;
    else if (vt < -36'sd32768) sat = 16'sh8000;
    else sat = vt[SampleW-1:0];
  end

  eatg_div #(.NumW(NumW), .DenW(LW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_len_q <= GapLengthRst;
      scale_q <= OutputScaleRst;
      phase_q <= '0;
      step_q <= '0;
      gain_q <= '0;
      on_len_q <= '0;
      total_q <= '0;
      tone_q <= '0;
      gap_q <= '0;
      rep_q <= '0;
    end else begin
      if (cfg_we_i && cfg_idx_i == CfgGapLength) gap_len_q <= cfg_wdata_i;
      if (cfg_we_i && cfg_idx_i == CfgOutputScale) scale_q <= cfg_wdata_i[ScaleW-1:0];
      if (cmd_i.load) begin
        step_q <= PW'(phase_step_i);
        on_len_q <= LW'(on_length_i);
        total_q <= LW'(on_length_i);
        tone_q <= LW'(on_length_i);
        gap_q <= '0;
        rep_q <= rep_count_i;
        gain_q <= (gain_i > GainOne) ? GainOne : gain_i;
      end else if (cmd_i.tick_zero) begin
        if (gap_q != '0) begin
          gap_q <= gap_q - 1'b1;
        end else if (rep_q != '0) begin
          rep_q <= rep_q - 1'b1;
          gap_q <= LW'(gap_len_q);
          tone_q <= on_len_q;
        end
      end else if (cmd_i.finish) begin
        phase_q <= phase_q + step_q;
        tone_q <= tone_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rel_latch) rel_q <= rel_prod[RelShift +: LW];
    if (cmd_i.env_one) env_q <= EnvW'(1) << EnvFrac;
    else if (cmd_i.env_latch) env_q <= div_quot[EnvW-1:0];
    if (cmd_i.rom_rd) rom_q <= sine_rom[rom_idx];
    if (cmd_i.s1_latch) s1_q <= rom_q;
    if (cmd_i.mul_op != MUL_NONE) mul_q <= ProdW'(mul_a * mul_b);
    if (cmd_i.tick_zero) sample_q <= '0;
    else if (cmd_i.finish) sample_q <= sat;
  end

  assign sample_o = sample_q;

  `ASSERT_ALWAYS(a_tone_in_burst, clk_i, rst_ni, tone_q <= total_q, "tone count beyond burst length")
  `ASSERT_ALWAYS(a_on_eq_total, clk_i, rst_ni, on_len_q == total_q, "burst length copies differ")
endmodule

FILE: sv/eatg_ctrl.sv
// Controller FSM: accepts items, sequences the burst sample computation, owns output valid.
// Depends on eatg_pkg and assert_macros.svh.
`timescale 1ns / 1ps
module eatg_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_action_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output eatg_pkg::dp_cmd_t cmd_o,
  input  eatg_pkg::dp_sts_t sts_i
);
  import eatg_pkg::*;
  `include "assert_macros.svh"

  ctrl_state_e state_q, state_d;
  logic        ovld_q, ovld_d;
  logic        slot_free, acc;

  assign slot_free = !ovld_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    cmd_o.mul_op = MUL_NONE;
    in_ready_o = (state_q == ST_IDLE) && slot_free;
    acc = in_valid_i && in_ready_o;
    ovld_d = ovld_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          if (in_action_i) begin
            cmd_o.load = 1'b1;
          end else if (sts_i.gap_nz || sts_i.tone_z) begin
            cmd_o.tick_zero = 1'b1;
            ovld_d = 1'b1;
          end else begin
            state_d = ST_REL;
          end
        end
      end
      ST_REL: begin
        cmd_o.rel_latch = 1'b1;
        state_d = ST_ENVSEL;
      end
      ST_ENVSEL: begin
        if (sts_i.env_full) begin
          cmd_o.env_one = 1'b1;
          state_d = ST_ROM1;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d = ST_ENV;
        end
      end
      ST_ENV: begin
        if (sts_i.div_done) begin
          cmd_o.env_latch = 1'b1;
          state_d = ST_ROM1;
        end
      end
      ST_ROM1: begin
        cmd_o.rom_rd = 1'b1;
        state_d = ST_ROM2;
      end
      ST_ROM2: begin
        cmd_o.rom_rd = 1'b1;
        cmd_o.rom_hi = 1'b1;
        cmd_o.s1_latch = 1'b1;
        state_d = ST_HARM;
      end
      ST_HARM: begin
        cmd_o.mul_op = MUL_HARM;
        state_d = ST_ENVMUL;
      end
      ST_ENVMUL: begin
        cmd_o.mul_op = MUL_ENV;
        state_d = ST_GAIN;
      end
      ST_GAIN: begin
        cmd_o.mul_op = MUL_GAIN;
        state_d = ST_SCALE;
      end
      ST_SCALE: begin
        cmd_o.mul_op = MUL_SCALE;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) begin
          cmd_o.finish = 1'b1;
          ovld_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ovld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ovld_q <= ovld_d;
    end
  end

  assign out_valid_o = ovld_q;

  `ASSERT_ALWAYS(a_ready_idle, clk_i, rst_ni, !in_ready_o || state_q == ST_IDLE, "ready while busy")
  `ASSERT_NEXT(a_rel_to_env, clk_i, rst_ni, state_q == ST_REL, state_q == ST_ENVSEL, "release latch skipped")
  `ASSERT_NEXT(a_finish_valid, clk_i, rst_ni, cmd_o.finish || cmd_o.tick_zero, ovld_q, "result beat lost")
endmodule

FILE: sv/enveloped_alarm_tone_generator.sv
// Top level of the enveloped alarm tone generator: controller plus datapath.
// Depends on eatg_pkg, eatg_in_if, eatg_out_if, eatg_ctrl, eatg_dp.
//
//   channel   dir  beat payload
//   in_chan   in   action, phase_step, on_length, rep_count, gain
//   out_chan  out  sample (one per sample tick)
//   cfg_*     in   gap_length (idx 0), output_scale (idx 1)
//
// Start beats and gap/idle ticks are handled in the idle state; a burst tick
// runs release, envelope select, the serial envelope divide on attack or
// release only, two ROM reads, four multiplies and the done state.
// A finished sample waits in the output register; a new beat is taken once
// that register is empty or draining. Reset is asynchronous, active low.
`timescale 1ns / 1ps
module enveloped_alarm_tone_generator #(
  parameter int unsigned SINE_TABLE_DEPTH = eatg_pkg::SineDepthDef,
  parameter int unsigned PHASE_WIDTH = eatg_pkg::PhaseWidthDef,
  parameter int unsigned LENGTH_WIDTH = eatg_pkg::LengthWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  eatg_in_if.sink                       in_chan,
  eatg_out_if.source                    out_chan,
  input  logic                          cfg_we_i,
  input  logic [eatg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [eatg_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import eatg_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  eatg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_chan.valid),
    .in_action_i(in_chan.action),
    .in_ready_o (in_chan.ready),
    .out_valid_o(out_chan.valid),
    .out_ready_i(out_chan.ready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  eatg_dp #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
    .PHASE_WIDTH     (PHASE_WIDTH),
    .LENGTH_WIDTH    (LENGTH_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .phase_step_i  (in_chan.phase_step),
    .on_length_i   (in_chan.on_length),
    .rep_count_i   (in_chan.rep_count),
    .gain_i        (in_chan.gain),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .sample_o      (out_chan.sample)
  );
endmodule

FILE: dv/enveloped_alarm_tone_generator_tb.sv
// Self-checking testbench for the enveloped alarm tone generator.
// Needs eatg_pkg, eatg_in_if, eatg_out_if and the RTL top; a directed table,
// then random beeps and ticks, each sample checked against a tone predictor.
`timescale 1ns / 1ps
module enveloped_alarm_tone_generator_tb;
  import eatg_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;
  localparam int unsigned CycleLimit = 4000000;
  localparam int unsigned DrainCycles = 150;
  localparam int unsigned RandPerPhase = 460;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  typedef struct {
    logic              action;
    logic [StepW-1:0]  step;
    logic [InLenW-1:0] len;
    logic [RepW-1:0]   rep;
    logic [GainW-1:0]  gain;
    bit                known;
    logic signed [SampleW-1:0] sample;
  } tone_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  eatg_in_if in_bus();
  eatg_out_if out_bus();

  enveloped_alarm_tone_generator dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_chan(in_bus), .out_chan(out_bus),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_wdata_i(cfg_wdata_i)
  );

  // predictor state
  logic [15:0] m_gap_length;
  logic [14:0] m_output_scale;
  logic [23:0] m_phase;
  logic [22:0] m_step;
  logic [15:0] m_gain;
  logic [15:0] m_on_length;
  logic [15:0] m_total;
  logic [15:0] m_tone_left;
  logic [15:0] m_gap_left;
  logic [7:0]  m_repeats_left;

  logic signed [SampleW-1:0] samples_due[$];
  tone_row_t rows[$];
  idle_mode_e idle_mode;
  int unsigned errors;
  int unsigned cycles;
  int unsigned hold_req;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("enveloped_alarm_tone_generator_tb: errors");
      $finish;
    end
  end

  function automatic longint sine_q15(logic [9:0] k);
    longint unsigned u, quad, rem, t, t2, a, b, c, s, r;
    u = 64'(k) << 2;
    quad = (u >> 10) & 64'd3;
    rem = u & 64'd1023;
    t = rem << 20;
    if (quad[0]) t = (64'd1 << 30) - t;
    t2 = (t * t) >> 30;
    a = C3 - ((t2 * C4) >> 30);
    b = C2 - ((t2 * a) >> 30);
    c = C1 - ((t2 * b) >> 30);
    s = (t * c) >> 30;
    r = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    if (r > 64'd32767) r = 64'd32767;
    return quad[1] ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint round_away(longint x, int n);
    longint m;
    m = x < 0 ? -x : x;
    m = (m + (longint'(1) << (n - 1))) >>> n;
    return x < 0 ? -m : m;
  endfunction

  function automatic longint trunc_zero(longint x, int n);
    longint m;
    m = x < 0 ? -x : x;
    m = m >>> n;
    return x < 0 ? -m : m;
  endfunction

  function automatic logic signed [15:0] burst_value();
    longint total, left, played, attack, release_len, env, s1, s2, wave, v;
    logic [23:0] ph2;
    total = m_total;
    left = m_tone_left;
    played = left > total ? 0 : total - left;
    attack = total / 8;
    release_len = total / 5;
    if (attack < 1) attack = 1;
    if (release_len < 1) release_len = 1;
    env = 65536;
    if (played < attack) env = (played * 65536) / attack;
    else if (left < release_len) env = (left * 65536) / release_len;
    ph2 = m_phase << 1;
    s1 = sine_q15(m_phase[23:14]);
    s2 = sine_q15(ph2[23:14]);
    wave = s1 + round_away(s2 * longint'(HarmQ15), 15);
    v = round_away(wave * env, 16);
    v = round_away(v * longint'(m_gain), 15);
    v = trunc_zero(v * longint'(m_output_scale), 15);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // advances the predictor by one beat; returns 1 when a sample is due
  function automatic bit tone_advance(tone_row_t it, output logic signed [15:0] smp);
    smp = '0;
    if (it.action) begin
      m_step = it.step;
      m_on_length = it.len;
      m_total = it.len;
      m_tone_left = it.len;
      m_gap_left = '0;
      m_repeats_left = it.rep;
      m_gain = it.gain > GainOne ? GainOne : it.gain;
      return 1'b0;
    end
    if (m_gap_left != 0) begin
      m_gap_left = m_gap_left - 1;
      return 1'b1;
    end
    if (m_tone_left == 0) begin
      if (m_repeats_left != 0) begin
        m_repeats_left = m_repeats_left - 1;
        m_gap_left = m_gap_length;
        m_tone_left = m_on_length;
      end
      return 1'b1;
    end
    smp = burst_value();
    m_phase = m_phase + 24'(m_step);
    m_tone_left = m_tone_left - 1;
    return 1'b1;
  endfunction

  task automatic add_row(logic a, logic [22:0] st, logic [15:0] ln, logic [7:0] rp,
                         logic [15:0] g, bit known, logic signed [15:0] smp);
    tone_row_t r;
    r.action = a; r.step = st; r.len = ln; r.rep = rp; r.gain = g;
    r.known = known; r.sample = smp;
    rows.push_back(r);
  endtask

  task automatic send_beat(tone_row_t it);
    logic signed [15:0] smp;
    in_bus.valid <= 1'b1;
    in_bus.action <= it.action;
    in_bus.phase_step <= it.step;
    in_bus.on_length <= it.len;
    in_bus.rep_count <= it.rep;
    in_bus.gain <= it.gain;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    if (tone_advance(it, smp)) samples_due.push_back(it.known ? it.sample : smp);
    if (idle_mode == IDLE_SEND || idle_mode == IDLE_BOTH) begin
      while ($urandom_range(99) < (idle_mode == IDLE_SEND ? 81 : 38)) begin
        in_bus.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
  endtask

  // leaves the write enable high; the caller drops it after its last write
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    if (idx == CfgGapLength) m_gap_length = val;
    else if (idx == CfgOutputScale) m_output_scale = val[14:0];
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    while (samples_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic tone_row_t random_row();
    tone_row_t r;
    r.known = 1'b0;
    r.sample = '0;
    r.action = ($urandom_range(11) == 0);
    r.step = StepW'($urandom());
    r.gain = ($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(32768));
    r.len = ($urandom_range(39) == 0) ? 16'($urandom()) : 16'($urandom_range(40));
    r.rep = ($urandom_range(19) == 0) ? 8'($urandom()) : 8'($urandom_range(3));
    return r;
  endfunction

  // receiver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else if (hold_req != 0) begin
      out_bus.ready <= 1'b0;
      hold_req <= hold_req - 1;
    end else if (idle_mode == IDLE_RECV) begin
      out_bus.ready <= ($urandom_range(99) >= 81);
    end else if (idle_mode == IDLE_BOTH) begin
      out_bus.ready <= ($urandom_range(99) >= 38);
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  // checker
  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (samples_due.size() == 0) begin
        $error("unexpected sample beat: sample actual %0d", out_bus.sample);
        errors++;
      end else begin
        if (out_bus.sample !== samples_due[0]) begin
          $error("sample: expected %0d actual %0d", samples_due[0], out_bus.sample);
          errors++;
        end
        void'(samples_due.pop_front());
      end
    end
  end

  initial begin
    logic [15:0] gap_set[4];
    logic [15:0] scale_set[4];
    errors = 0;
    cycles = 0;
    hold_req = 0;
    idle_mode = IDLE_NONE;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    in_bus.valid = 1'b0;
    in_bus.action = 1'b0;
    in_bus.phase_step = '0;
    in_bus.on_length = '0;
    in_bus.rep_count = '0;
    in_bus.gain = '0;
    m_gap_length = GapLengthRst;
    m_output_scale = OutputScaleRst;
    m_phase = '0; m_step = '0; m_gain = '0; m_on_length = '0; m_total = '0;
    m_tone_left = '0; m_gap_left = '0; m_repeats_left = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_row(0, 0, 0, 0, 0, 1, 0);
    add_row(1, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, 0, 0, 0, 1, 0);
    add_row(1, 23'h7fffff, 1, 0, 16'hffff, 0, 0);
    add_row(0, 0, 0, 0, 0, 1, 0);
    add_row(0, 0, 0, 0, 0, 1, 0);
    add_row(1, 23'h400000, 10, 1, GainOne, 0, 0);
    add_row(0, 0, 0, 0, 0, 1, 0);
    repeat (9) add_row(0, 23'h7fffff, 16'hffff, 8'hff, 16'hffff, 0, 0);
    add_row(0, 0, 0, 0, 0, 1, 0);
    add_row(0, 0, 0, 0, 0, 1, 0);
    add_row(1, 23'd12345, 16'hffff, 8'hff, GainOne, 0, 0);
    repeat (3) add_row(0, 0, 0, 0, 0, 0, 0);
    add_row(1, 23'd99999, 3, 0, 16'd1, 0, 0);
    repeat (3) add_row(0, 0, 0, 0, 0, 0, 0);
    foreach (rows[i]) send_beat(rows[i]);
    drain();

    gap_set = '{16'd0, 16'd5, 16'hffff, 16'd3};
    scale_set = '{16'h7fff, 16'd0, 16'd14000, 16'h7fff};
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(CfgGapLength, gap_set[ph]);
      write_reg(CfgOutputScale, scale_set[ph]);
      write_reg(CfgUnused, 16'hffff);
      cfg_we_i <= 1'b0;
      idle_mode = idle_mode_e'(ph);
      if (ph == 0) hold_req <= 3000;
      for (int n = 0; n < RandPerPhase; n++) send_beat(random_row());
      drain();
    end

    if (errors == 0) begin
      $display("enveloped_alarm_tone_generator_tb: clean");
    end else begin
      $display("enveloped_alarm_tone_generator_tb: errors");
    end
    $finish;
  end

endmodule
